// File: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box and round helpers for the AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned CfgIdxW   = 1;

	localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} aes_out_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// byte i of a 128-bit word, byte 0 most significant
	function automatic logic [7:0] get_byte(input logic [127:0] w, input int unsigned i);
		get_byte = w[127-8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a [4];
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = get_byte(s, 4*c+r);
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)%4]) ^ a[(r+1)%4]
					^ a[(r+2)%4] ^ a[(r+3)%4];
			end
		end
		mix_columns = t;
	endfunction

	// one step of the key schedule: previous round key to the next
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w [4];
		logic [31:0] t;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		next_key = {w[0], w[1], w[2], w[3]};
	endfunction

endpackage

// File: rtl/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// One registered cipher round with its key-schedule step alongside.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld,
	input  logic [127:0] state,
	input  logic [127:0] rkey,
	input  logic [7:0]   rcon,
	input  logic         last,
	output logic         vld_s1,
	output logic [127:0] state_s1,
	output logic [127:0] rkey_s1
);

	logic [127:0] key_nxt;
	logic [127:0] sb;
	logic [127:0] mixed;

	assign key_nxt = next_key(rkey, rcon);
	assign sb      = sub_shift(state);
	assign mixed   = last ? sb : mix_columns(sb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// payload advances with its item's key so a key change never mixes items
	always_ff @(posedge clk) begin
		state_s1 <= mixed ^ key_nxt;
		rkey_s1  <= key_nxt;
	end

endmodule

// File: rtl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// AES-128 encryption pipeline: one 128-bit block per cycle, ten round stages.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  config   | in        | cfg_we            | cfg_idx, cfg_data (key halves)
//  block in | in        | start & !busy     | din  (aes_in_t)
//  result   | out       | done (one cycle)  | dout (aes_out_t)
//
// An accepted beat passes through one stage for the initial AddRoundKey,
// then one stage per round. One beat per cycle is taken.
// busy is tied low; the result receiver cannot stall, so nothing ever holds.
// Reset clears the key registers and every stage valid bit.
// The round keys travel down the pipe with their block, so key writes affect
// only beats accepted after the write.
module aes128_block_encrypt import aes_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [63:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  aes_in_t            din,
	output logic               done,
	output aes_out_t           dout
);

	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic         vld   [NumRounds+1];
	logic [127:0] st    [NumRounds+1];
	logic [127:0] rk    [NumRounds+1];

	assign busy = 1'b0;

	// hold the key; writes to unknown indexes cannot occur with a 1-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage zero: initial AddRoundKey, capture the key with the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else begin
			vld[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		st[0] <= {din.plain_high, din.plain_low} ^ {key_high_q, key_low_q};
		rk[0] <= {key_high_q, key_low_q};
	end

	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		aes_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (vld[r]),
			.state    (st[r]),
			.rkey     (rk[r]),
			.rcon     (RCON[r]),
			.last     (r == NumRounds-1),
			.vld_s1   (vld[r+1]),
			.state_s1 (st[r+1]),
			.rkey_s1  (rk[r+1])
		);
	end

	assign done             = vld[NumRounds];
	assign dout.cipher_high = st[NumRounds][127:64];
	assign dout.cipher_low  = st[NumRounds][63:0];

	// a beat taken now must surface after the full pipe depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##11 done) else $error("result missing after pipe delay");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 11)) else $error("result without a beat");
	a_stage_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] |=> vld[1]) else $error("valid lost between stages");

endmodule
